// File: sv/jtpm_pkg.sv
// jtpm_pkg: shared types and constants for the two-wire JTAG phase master.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package jtpm_pkg;

  // Sequence kind; the start opcodes use the same encoding.
  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_XFER  = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_LEAVE = 2'd3
  } kind_t;

  localparam int unsigned TRANSFER_BITS = 8;
  // Clamp for the bit count; bit_count is four bits wide.
  localparam int unsigned XFER_LIMIT    = (TRANSFER_BITS > 15) ? 15 : TRANSFER_BITS;
  localparam logic [31:0] KEY_RESET     = 32'h4D43_4850;
  localparam int unsigned KEY_BITS      = 32;
  localparam int unsigned BYTE_BITS     = 8;

  // Transfer phases within one bit.
  localparam logic [3:0] PH_TDI     = 4'd0;
  localparam logic [3:0] PH_TDI_LO  = 4'd1;
  localparam logic [3:0] PH_TMS     = 4'd2;
  localparam logic [3:0] PH_TMS_LO  = 4'd3;
  localparam logic [3:0] PH_RELEASE = 4'd4;
  localparam logic [3:0] PH_SAMPLE  = 4'd5;

  // Entry phases.
  localparam logic [3:0] PH_EN_START = 4'd0;
  localparam logic [3:0] PH_EN_DATA  = 4'd1;
  localparam logic [3:0] PH_EN_CLOCK = 4'd2;
  localparam logic [3:0] PH_EN_END   = 4'd3;

  // Leave phases.
  localparam logic [3:0] PH_LV_START = 4'd0;
  localparam logic [3:0] PH_LV_END   = 4'd1;

endpackage

`default_nettype wire

// File: sv/jtpm_if.sv
// jtpm_if: valid/ready channel interfaces for the JTAG phase master.
// Depends on jtpm_pkg for field widths.
`default_nettype none

interface jtpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] tms_bits;
  logic [7:0] tdi_bits;
  logic [3:0] bit_count;
  logic       data_pin_in;

  modport source (output valid, op, tms_bits, tdi_bits, bit_count, data_pin_in,
                  input ready);
  modport sink   (input valid, op, tms_bits, tdi_bits, bit_count, data_pin_in,
                  output ready);
endinterface

interface jtpm_out_if;
  logic       valid;
  logic       ready;
  logic       clock_out;
  logic       clock_drive;
  logic       data_out;
  logic       data_drive;
  logic       reset_out;
  logic       reset_drive;
  logic       busy_res;
  logic       done_res;
  logic [jtpm_pkg::BYTE_BITS-1:0] rx_bits;
  logic       rejected;

  modport source (output valid, clock_out, clock_drive, data_out, data_drive,
                  reset_out, reset_drive, busy_res, done_res, rx_bits, rejected,
                  input ready);
  modport sink   (input valid, clock_out, clock_drive, data_out, data_drive,
                  reset_out, reset_drive, busy_res, done_res, rx_bits, rejected,
                  output ready);
endinterface

interface jtpm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/two_wire_jtag_phase_master_unit.sv
// two_wire_jtag_phase_master_unit: tick-driven two-wire JTAG master, top level.
// Depends on jtpm_pkg and the channel interfaces in jtpm_if.sv.
//
//  channel | dir | payload                                          | beat
//  --------+-----+--------------------------------------------------+---------------
//  in_bus  | in  | op, tms_bits, tdi_bits, bit_count, data_pin_in   | one tick
//  out_bus | out | pin levels/drives, busy, done, rx_bits, rejected | one per tick
//  cfg_bus | in  | data = entry_key                                 | register write
//
// One tick per clock sustained while out_bus.ready is high. An input beat lands
// in the input register, then runs through the sequencer logic into the output
// register once the output slot is free. The output register stalls the tick
// logic only while a result is waiting on out_bus.ready; the input register
// keeps taking beats while it can drain. Reset (rst_n low, synchronous) puts
// all pins released and low, sequencer idle, entry_key = 0x4D434850.
`default_nettype none

module two_wire_jtag_phase_master_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  jtpm_in_if.sink     in_bus,
  jtpm_out_if.source  out_bus,
  jtpm_cfg_if.sink    cfg_bus
);

  // ---------------- configuration ----------------
  logic [31:0] entry_key_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_key_r <= jtpm_pkg::KEY_RESET;
    end else if (cfg_bus.valid) begin
      entry_key_r <= cfg_bus.data;
    end
  end

  // ---------------- input register ----------------
  logic       in_vld_r;
  logic [1:0] in_op_r;
  logic [7:0] in_tms_r;
  logic [7:0] in_tdi_r;
  logic [3:0] in_cnt_r;
  logic       in_pin_r;
  logic       out_vld_r;
  logic       advance;

  // Tick logic fires when an item is held and the output slot is free.
  assign advance      = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_op_r  <= in_bus.op;
      in_tms_r <= in_bus.tms_bits;
      in_tdi_r <= in_bus.tdi_bits;
      in_cnt_r <= in_bus.bit_count;
      in_pin_r <= in_bus.data_pin_in;
    end
  end

  // ---------------- sequencer state ----------------
  jtpm_pkg::kind_t kind_r,  kind_nxt;
  logic [3:0] phase_r,      phase_nxt;
  logic [5:0] bidx_r,       bidx_nxt;
  logic [7:0] tms_sh_r,     tms_sh_nxt;
  logic [7:0] tdi_sh_r,     tdi_sh_nxt;
  logic [3:0] total_r,      total_nxt;
  logic [7:0] rx_sh_r,      rx_sh_nxt;
  logic       prev_tdo_r,   prev_tdo_nxt;
  logic       clk_o_r,      clk_o_nxt;
  logic       clk_d_r,      clk_d_nxt;
  logic       dat_o_r,      dat_o_nxt;
  logic       dat_d_r,      dat_d_nxt;
  logic       rst_o_r,      rst_o_nxt;
  logic       rst_d_r,      rst_d_nxt;

  logic       done_c;
  logic       rej_c;
  logic       fin_c;
  logic [7:0] rx_c;
  logic [3:0] cnt_clamped;
  logic [5:0] bidx_inc;
  logic [5:0] nb;

  localparam logic [3:0] LIMIT = 4'(jtpm_pkg::XFER_LIMIT);

  assign cnt_clamped = (in_cnt_r > LIMIT) ? LIMIT : in_cnt_r;
  assign nb          = bidx_r + 6'd1;

  always_comb begin
    kind_nxt     = kind_r;
    phase_nxt    = phase_r;
    bidx_nxt     = bidx_r;
    tms_sh_nxt   = tms_sh_r;
    tdi_sh_nxt   = tdi_sh_r;
    total_nxt    = total_r;
    rx_sh_nxt    = rx_sh_r;
    prev_tdo_nxt = prev_tdo_r;
    clk_o_nxt    = clk_o_r;
    clk_d_nxt    = clk_d_r;
    dat_o_nxt    = dat_o_r;
    dat_d_nxt    = dat_d_r;
    rst_o_nxt    = rst_o_r;
    rst_d_nxt    = rst_d_r;
    done_c       = 1'b0;
    rej_c        = 1'b0;
    fin_c        = 1'b0;
    rx_c         = '0;
    bidx_inc     = '0;

    // Start handling. A start while busy is dropped and flagged.
    if (kind_r != jtpm_pkg::KIND_IDLE) begin
      rej_c = (in_op_r != 2'(jtpm_pkg::KIND_IDLE));
    end else if (in_op_r != 2'(jtpm_pkg::KIND_IDLE)) begin
      kind_nxt  = jtpm_pkg::kind_t'(in_op_r);
      phase_nxt = '0;
      bidx_nxt  = '0;
      if (in_op_r == 2'(jtpm_pkg::KIND_XFER)) begin
        total_nxt  = cnt_clamped;
        tms_sh_nxt = in_tms_r;
        tdi_sh_nxt = in_tdi_r;
        rx_sh_nxt  = {7'd0, prev_tdo_r};
        // Zero-bit transfer completes on the start tick with no pin action.
        if (cnt_clamped == 4'd0) begin
          rx_sh_nxt = '0;
          kind_nxt  = jtpm_pkg::KIND_IDLE;
          done_c    = 1'b1;
        end
      end
    end

    // One action of the running (or just started) sequence.
    case (kind_nxt)
      jtpm_pkg::KIND_XFER: begin
        case (phase_nxt)
          jtpm_pkg::PH_TDI: begin
            clk_o_nxt = 1'b1;
            dat_o_nxt = tdi_sh_nxt[0];
            dat_d_nxt = 1'b1;
          end
          jtpm_pkg::PH_TDI_LO: begin
            clk_o_nxt  = 1'b0;
            tdi_sh_nxt = tdi_sh_nxt >> 1;
          end
          jtpm_pkg::PH_TMS: begin
            clk_o_nxt = 1'b1;
            dat_o_nxt = tms_sh_nxt[0];
          end
          jtpm_pkg::PH_TMS_LO: begin
            clk_o_nxt  = 1'b0;
            tms_sh_nxt = tms_sh_nxt >> 1;
          end
          jtpm_pkg::PH_RELEASE: begin
            clk_o_nxt = 1'b0;
            dat_d_nxt = 1'b0;
          end
          jtpm_pkg::PH_SAMPLE: begin
            clk_o_nxt = 1'b1;
            // This state never runs on the start tick, so bidx_r is current.
            if (nb < {2'd0, total_nxt}) begin
              if (nb < 6'd8) begin
                rx_sh_nxt[nb[2:0]] = rx_sh_nxt[nb[2:0]] | in_pin_r;
              end
            end else begin
              prev_tdo_nxt = in_pin_r;
            end
          end
          default: begin
            clk_o_nxt = 1'b0;
            bidx_inc  = bidx_nxt + 6'd1;
            bidx_nxt  = bidx_inc;
            fin_c     = (bidx_inc >= {2'd0, total_nxt});
            rx_c      = fin_c ? rx_sh_nxt : 8'd0;
          end
        endcase
        // phase 6 wraps to 0; others step
        if (phase_nxt > jtpm_pkg::PH_SAMPLE) begin
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_nxt + 4'd1;
        end
      end
      jtpm_pkg::KIND_ENTRY: begin
        case (phase_nxt)
          jtpm_pkg::PH_EN_START: begin
            clk_o_nxt = 1'b0;
            clk_d_nxt = 1'b1;
            dat_o_nxt = 1'b0;
            dat_d_nxt = 1'b1;
            rst_o_nxt = 1'b1;
            rst_d_nxt = 1'b1;
            phase_nxt = jtpm_pkg::PH_EN_DATA;
          end
          jtpm_pkg::PH_EN_DATA: begin
            rst_o_nxt = 1'b0;
            clk_o_nxt = 1'b0;
            // MSB first: bit 31 - index
            dat_o_nxt = entry_key_r[~bidx_nxt[4:0]];
            phase_nxt = jtpm_pkg::PH_EN_CLOCK;
          end
          jtpm_pkg::PH_EN_CLOCK: begin
            clk_o_nxt = 1'b1;
            bidx_inc  = bidx_nxt + 6'd1;
            bidx_nxt  = bidx_inc;
            phase_nxt = (bidx_inc >= 6'(jtpm_pkg::KEY_BITS)) ? jtpm_pkg::PH_EN_END
                                                            : jtpm_pkg::PH_EN_DATA;
          end
          default: begin
            clk_o_nxt = 1'b0;
            dat_o_nxt = 1'b0;
            rst_o_nxt = 1'b1;
            fin_c     = 1'b1;
          end
        endcase
      end
      jtpm_pkg::KIND_LEAVE: begin
        if (phase_nxt == jtpm_pkg::PH_LV_START) begin
          rst_o_nxt = 1'b0;
          rst_d_nxt = 1'b1;
          phase_nxt = jtpm_pkg::PH_LV_END;
        end else begin
          clk_d_nxt = 1'b0;
          dat_d_nxt = 1'b0;
          rst_o_nxt = 1'b1;
          rst_d_nxt = 1'b0;
          fin_c     = 1'b1;
        end
      end
      default: ;
    endcase

    if (fin_c) begin
      kind_nxt  = jtpm_pkg::KIND_IDLE;
      phase_nxt = '0;
      bidx_nxt  = '0;
      done_c    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= jtpm_pkg::KIND_IDLE;
      phase_r    <= '0;
      bidx_r     <= '0;
      tms_sh_r   <= '0;
      tdi_sh_r   <= '0;
      total_r    <= '0;
      rx_sh_r    <= '0;
      prev_tdo_r <= 1'b0;
      clk_o_r    <= 1'b0;
      clk_d_r    <= 1'b0;
      dat_o_r    <= 1'b0;
      dat_d_r    <= 1'b0;
      rst_o_r    <= 1'b0;
      rst_d_r    <= 1'b0;
    end else if (advance) begin
      kind_r     <= kind_nxt;
      phase_r    <= phase_nxt;
      bidx_r     <= bidx_nxt;
      tms_sh_r   <= tms_sh_nxt;
      tdi_sh_r   <= tdi_sh_nxt;
      total_r    <= total_nxt;
      rx_sh_r    <= rx_sh_nxt;
      prev_tdo_r <= prev_tdo_nxt;
      clk_o_r    <= clk_o_nxt;
      clk_d_r    <= clk_d_nxt;
      dat_o_r    <= dat_o_nxt;
      dat_d_r    <= dat_d_nxt;
      rst_o_r    <= rst_o_nxt;
      rst_d_r    <= rst_d_nxt;
    end
  end

  // ---------------- output register ----------------
  logic       o_clk_o_r, o_clk_d_r, o_dat_o_r, o_dat_d_r, o_rst_o_r, o_rst_d_r;
  logic       o_busy_r, o_done_r, o_rej_r;
  logic [7:0] o_rx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_clk_o_r <= clk_o_nxt;
      o_clk_d_r <= clk_d_nxt;
      o_dat_o_r <= dat_o_nxt;
      o_dat_d_r <= dat_d_nxt;
      o_rst_o_r <= rst_o_nxt;
      o_rst_d_r <= rst_d_nxt;
      o_busy_r  <= (kind_nxt != jtpm_pkg::KIND_IDLE);
      o_done_r  <= done_c;
      o_rx_r    <= rx_c;
      o_rej_r   <= rej_c;
    end
  end

  assign out_bus.valid       = out_vld_r;
  assign out_bus.clock_out   = o_clk_o_r;
  assign out_bus.clock_drive = o_clk_d_r;
  assign out_bus.data_out    = o_dat_o_r;
  assign out_bus.data_drive  = o_dat_d_r;
  assign out_bus.reset_out   = o_rst_o_r;
  assign out_bus.reset_drive = o_rst_d_r;
  assign out_bus.busy_res    = o_busy_r;
  assign out_bus.done_res    = o_done_r;
  assign out_bus.rx_bits     = o_rx_r;
  assign out_bus.rejected    = o_rej_r;

endmodule

`default_nettype wire

// File: sv/jtpm_checker.sv
// jtpm_checker: port-level assertions for two_wire_jtag_phase_master_unit.
// Bound to the top level below; sees only its ports.
`default_nettype none

module jtpm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_busy,
  input wire logic       out_done,
  input wire logic       out_rejected,
  input wire logic [7:0] out_rx
);

  logic last_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_busy_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_busy_r <= out_busy;
    end
  end

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_busy, out_done, out_rejected, out_rx}))
    else $error("out beat changed while stalled");

  // finishing tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> !out_busy)
    else $error("done with busy still set");

  // received byte only on a finishing tick
  a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rx != 8'd0) |-> out_done)
    else $error("rx_bits nonzero outside done");

  // a reject needs a sequence running after the previous tick
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> last_busy_r)
    else $error("reject while idle");

endmodule

bind two_wire_jtag_phase_master_unit jtpm_checker u_jtpm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_busy     (out_bus.busy_res),
  .out_done     (out_bus.done_res),
  .out_rejected (out_bus.rejected),
  .out_rx       (out_bus.rx_bits)
);

`default_nettype wire
